// File: hw/rtl/qpe_pkg.sv
// qpe_pkg: shared types, constants and helpers for the quoted-printable encoder.
// No dependencies; imported by every module of the block.
package qpe_pkg;

  localparam logic [9:0]  DefaultLineLength = 10'd70;
  localparam logic [10:0] MaxLineLength     = 11'd1023;
  localparam int unsigned MaxBytes          = 5;
  localparam int unsigned CmdDepth          = 2;

  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChDot = 8'h2E;
  localparam logic [7:0] ChEq  = 8'h3D;
  localparam logic [7:0] ChDel = 8'h7F;

  typedef enum logic [1:0] {
    MarkNone = 2'd0,
    MarkLf   = 2'd1,
    MarkDot  = 2'd2
  } qpe_mark_e;

  // One encoded burst: up to five bytes, sent in order from bytes[0].
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               count;
  } qpe_cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) r = 8'h30 + {4'h0, nib};
    else             r = 8'h37 + {4'h0, nib};
    return r;
  endfunction

  // Expected next character of LF "From " at match position idx.
  function automatic logic [7:0] from_expect(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = ChLf;
      3'd1:    r = 8'h46;
      3'd2:    r = 8'h72;
      3'd3:    r = 8'h6F;
      3'd4:    r = 8'h6D;
      3'd5:    r = ChSp;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/qpe_front.sv
// qpe_front: holds line_length and the line state, classifies each input word
// and builds its encoded burst. Depends on qpe_pkg.
module qpe_front import qpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_input_i,
  output qpe_cmd_t   cmd_o
);

  logic [9:0]  line_length_q;
  logic [10:0] col_q, col_d;
  logic        sp_q, sp_d;
  qpe_mark_e   lsm_q, lsm_d;
  logic [2:0]  fmi_q, fmi_d;

  logic [10:0] limit;
  logic [10:0] col_inc1, col_inc3;
  logic [7:0]  expect_ch;
  logic [7:0]  c;
  logic        is_esc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= DefaultLineLength;
    end else if (cfg_we_i) begin
      line_length_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    limit = {1'b0, line_length_q};
    if (line_length_q == '0) limit = {1'b0, DefaultLineLength};
    if (limit > MaxLineLength) limit = MaxLineLength;
  end

  assign c         = data_byte_i;
  assign col_inc1  = col_q + 11'd1;
  assign col_inc3  = col_q + 11'd3;
  assign expect_ch = from_expect(fmi_q);
  assign is_esc    = (c < ChSp) || (c == ChEq) || (c >= ChDel);

  always_comb begin
    col_d = col_q;
    sp_d  = sp_q;
    lsm_d = lsm_q;
    fmi_d = fmi_q;
    cmd_o = '0;
    priority if (end_of_input_i) begin
      if (col_q != '0) begin
        cmd_o.bytes[0] = ChEq;
        cmd_o.bytes[1] = ChLf;
        cmd_o.count    = 3'd2;
      end
      col_d = '0;
      sp_d  = 1'b0;
      lsm_d = MarkNone;
      fmi_d = 3'd1;
    end else if (c == ChTab || c == ChSp) begin
      fmi_d = 3'd0;
      if (expect_ch == c) begin
        // space of "From " at line start
        cmd_o.bytes[0] = ChEq;
        cmd_o.bytes[1] = hex_char(c[7:4]);
        cmd_o.bytes[2] = hex_char(c[3:0]);
        cmd_o.count    = 3'd3;
        col_d          = col_inc3;
      end else begin
        sp_d           = 1'b1;
        cmd_o.bytes[0] = c;
        cmd_o.count    = 3'd1;
        col_d          = col_inc1;
        if (col_inc1 > limit) begin
          sp_d           = 1'b0;
          col_d          = '0;
          lsm_d          = MarkLf;
          fmi_d          = 3'd1;
          cmd_o.bytes[1] = ChEq;
          cmd_o.bytes[2] = ChLf;
          cmd_o.count    = 3'd3;
        end
      end
    end else if (c == ChLf) begin
      if (sp_q || lsm_q == MarkDot) begin
        cmd_o.bytes[0] = ChEq;
        cmd_o.bytes[1] = ChLf;
        cmd_o.bytes[2] = ChLf;
        cmd_o.count    = 3'd3;
      end else begin
        cmd_o.bytes[0] = ChLf;
        cmd_o.count    = 3'd1;
      end
      sp_d  = 1'b0;
      col_d = '0;
      lsm_d = MarkLf;
      fmi_d = 3'd1;
    end else if (is_esc) begin
      sp_d           = 1'b0;
      cmd_o.bytes[0] = ChEq;
      cmd_o.bytes[1] = hex_char(c[7:4]);
      cmd_o.bytes[2] = hex_char(c[3:0]);
      cmd_o.count    = 3'd3;
      col_d          = col_inc3;
      if (col_inc3 > limit) begin
        col_d          = '0;
        lsm_d          = MarkLf;
        fmi_d          = 3'd1;
        cmd_o.bytes[3] = ChEq;
        cmd_o.bytes[4] = ChLf;
        cmd_o.count    = 3'd5;
      end else begin
        fmi_d = 3'd0;
        lsm_d = MarkNone;
      end
    end else begin
      sp_d  = 1'b0;
      fmi_d = (expect_ch == c) ? fmi_q + 3'd1 : 3'd0;
      lsm_d = (c == ChDot && lsm_q == MarkLf) ? MarkDot : MarkNone;
      cmd_o.bytes[0] = c;
      cmd_o.count    = 3'd1;
      col_d          = col_inc1;
      if (col_inc1 > limit) begin
        col_d          = '0;
        lsm_d          = MarkLf;
        fmi_d          = 3'd1;
        cmd_o.bytes[1] = ChEq;
        cmd_o.bytes[2] = ChLf;
        cmd_o.count    = 3'd3;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      sp_q  <= 1'b0;
      lsm_q <= MarkNone;
      fmi_q <= 3'd1;
    end else if (accept_i) begin
      col_q <= col_d;
      sp_q  <= sp_d;
      lsm_q <= lsm_d;
      fmi_q <= fmi_d;
    end
  end

endmodule

// File: hw/rtl/qpe_fifo.sv
// qpe_fifo: two-entry queue of encoded bursts between front and back.
// Depends on qpe_pkg.
module qpe_fifo import qpe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  qpe_cmd_t wdata_i,
  input  logic     pop_i,
  output qpe_cmd_t rdata_o,
  output logic     empty_o,
  output logic     full_o
);

  localparam int unsigned PtrW = $clog2(CmdDepth);

  qpe_cmd_t              mem_q [CmdDepth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]         cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (PtrW+1)'(CmdDepth));
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: hw/rtl/qpe_back.sv
// qpe_back: walks the head burst into the output register, one byte per cycle unless the output stalls.
// Depends on qpe_pkg.
module qpe_back import qpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  qpe_cmd_t   head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       last_q;
  logic [2:0] idx_q, idx_d;
  logic       load, take, is_last;

  assign load    = !out_valid_q || out_ready_i;
  assign take    = load && !empty_i;
  assign is_last = (idx_q == head_i.count - 3'd1);
  assign pop_o   = take && is_last;
  assign idx_d   = is_last ? 3'd0 : idx_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) out_valid_q <= !empty_i;
      if (take) idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_byte_q <= head_i.bytes[idx_q];
      last_q     <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

endmodule

// File: hw/rtl/quoted_printable_encoder_core.sv
// quoted_printable_encoder_core: top level of the quoted-printable encoder.
// Depends on qpe_pkg, qpe_front, qpe_fifo and qpe_back.
//
// Takes one word per input handshake (a raw byte, or an end-of-input mark)
// and sends the quoted-printable text for it as a run of output words, one
// byte each, with last_o set on the final byte of the run. Control bytes other
// than tab and LF, '=' and bytes 0x7F and up go out as '=' plus two uppercase
// hex digits; the space of "From " at a line start goes out as "=20"; a soft
// break "=" LF follows a line that goes past line_length (0 acts as 70); a
// trailing space/tab or a lone-dot line gets "=" LF before its hard LF; end of
// input flushes "=" LF if the line is not empty and returns the line state to
// reset. An end mark on an empty line produces no output word. Timing: the
// front classifies and takes one input word per cycle while the queue has
// room; the back emits one byte per cycle unless the output stalls, and an
// item encodes to 0 to 5 bytes. A two-deep burst queue sits between them, so
// with single-byte items and no output stall the block runs at one item per
// cycle. Write line_length through cfg_we_i/cfg_wdata_i only while idle.
module quoted_printable_encoder_core import qpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  qpe_cmd_t cmd_new, cmd_head;
  logic     accept, cmd_push, cmd_pop, cmd_empty, cmd_full;

  // Input is held off only while the burst queue is full.
  assign in_ready_o = !cmd_full;
  assign accept     = in_valid_i && in_ready_o;
  // End marks on an empty line carry no bytes and never enter the queue.
  assign cmd_push   = accept && (cmd_new.count != 3'd0);

  qpe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_input_i(end_of_input_i),
    .cmd_o         (cmd_new)
  );

  qpe_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_new),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_head),
    .empty_o(cmd_empty),
    .full_o (cmd_full)
  );

  qpe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (cmd_head),
    .empty_i    (cmd_empty),
    .pop_o      (cmd_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  // Queue never overflows: a push only happens with room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_push |-> !cmd_full)
    else $error("burst pushed into full queue");

  // Queue never underflows.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> !cmd_empty)
    else $error("burst popped from empty queue");

  // Every queued burst holds one to five bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> (cmd_new.count >= 3'd1 && cmd_new.count <= 3'd5))
    else $error("burst byte count out of range");

  // A burst leaves the queue exactly when its last byte is loaded for output.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |=> (out_valid_o && last_o))
    else $error("queue pop without last byte on output");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for quoted_printable_encoder_core.
// Depends on qpe_pkg and the encoder RTL; keeps its own model of the encoder state.
module tb;
  import qpe_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 8;

  // LF "From " as a packed table, index 0 first; 6 and 7 never match a byte.
  localparam logic [0:7][7:0] FromSeq = {ChLf, 8'h46, 8'h72, 8'h6F, 8'h6D, ChSp,
                                         8'h00, 8'h00};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } qp_char_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic [9:0] cfg_wdata_i    = '0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i    = '0;
  logic       end_of_input_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_o;

  // Encoder state as the testbench sees it.
  logic [9:0]  line_len      = DefaultLineLength;
  logic [10:0] column        = '0;
  logic        blank_pending = 1'b0;
  qpe_mark_e   line_mark     = MarkNone;
  logic [2:0]  from_idx      = 3'd1;

  qp_char_t    encoded_q[$];
  int unsigned errors      = 0;
  int unsigned words_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          tx_gaps     = 1'b1;
  bit          rx_stalls   = 1'b1;

  quoted_printable_encoder_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the encoder hangs or drops words.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Encoding model
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10;
  endfunction

  function automatic void push_char(input logic [7:0] c);
    encoded_q.push_back('{ch: c, last: 1'b0});
  endfunction

  function automatic void push_hex(input logic [7:0] c);
    push_char(ChEq);
    push_char(hex_digit(c[7:4]));
    push_char(hex_digit(c[3:0]));
  endfunction

  function automatic void push_soft_break();
    push_char(ChEq);
    push_char(ChLf);
  endfunction

  function automatic void start_line();
    column    = '0;
    line_mark = MarkLf;
    from_idx  = 3'd1;
  endfunction

  // Appends the characters that one accepted word must produce.
  function automatic void predict_encoding(input logic [7:0] b, input logic eoi);
    logic [10:0] lim;
    logic [7:0]  from_next;
    int          first;
    first     = encoded_q.size();
    lim       = (line_len == '0) ? {1'b0, DefaultLineLength} : {1'b0, line_len};
    if (lim > MaxLineLength) lim = MaxLineLength;
    from_next = FromSeq[from_idx];

    if (eoi) begin
      if (column != '0) push_soft_break();
      // stream state back to reset, register kept
      column        = '0;
      blank_pending = 1'b0;
      line_mark     = MarkNone;
      from_idx      = 3'd1;
    end else if (b == ChTab || b == ChSp) begin
      if (from_next == b) begin
        // space of "From ": escaped, no limit check here
        push_hex(b);
        column   = column + 11'd3;
        from_idx = 3'd0;
      end else begin
        from_idx      = 3'd0;
        blank_pending = 1'b1;
        push_char(b);
        column = column + 11'd1;
        if (column > lim) begin
          blank_pending = 1'b0;
          start_line();
          push_soft_break();
        end
      end
    end else if (b == ChLf) begin
      if (blank_pending || line_mark == MarkDot) push_soft_break();
      blank_pending = 1'b0;
      start_line();
      push_char(ChLf);
    end else if (b < ChSp || b == ChEq || b >= ChDel) begin
      blank_pending = 1'b0;
      push_hex(b);
      column = column + 11'd3;
      if (column > lim) begin
        start_line();
        push_soft_break();
      end else begin
        from_idx  = 3'd0;
        line_mark = MarkNone;
      end
    end else begin
      blank_pending = 1'b0;
      from_idx  = (from_next == b) ? from_idx + 3'd1 : 3'd0;
      line_mark = (b == ChDot && line_mark == MarkLf) ? MarkDot : MarkNone;
      push_char(b);
      column = column + 11'd1;
      if (column > lim) begin
        start_line();
        push_soft_break();
      end
    end

    if (encoded_q.size() > first) encoded_q[encoded_q.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls and the word checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : out_side
    qp_char_t want;
    int       r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (encoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h last %b", out_byte_o, last_o));
      end else begin
        want = encoded_q.pop_front();
        if (out_byte_o !== want.ch)
          report_mismatch($sformatf("byte %h, want %h", out_byte_o, want.ch));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %b, want %b (byte %h)", last_o, want.last,
                                    want.ch));
      end
    end

    // mostly ready, short stalls often, long ones now and then
    if (!rx_stalls) begin
      stall_left  = 0;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ready_i <= 1'b1;
      end else begin
        stall_left  = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        out_ready_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    int r;
    if (!tx_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input logic [7:0] b, input logic eoi);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    end_of_input_i <= eoi;
    predict_encoding(b, eoi);
    words_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Waits for every expected word, then lets the pipe settle
  // (an end mark on an empty line makes no word).
  task automatic drain_encoder();
    in_valid_i <= 1'b0;
    while (encoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_line_length(input logic [9:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    line_len     = v;
  endtask

  // One piece of plausible text: mostly well-formed, some noise.
  task automatic send_text_chunk();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_word(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
    end else if (r < 57) begin
      send_word(($urandom_range(0, 1) != 0) ? ChSp : ChTab, 1'b0);
    end else if (r < 66) begin
      send_word(ChLf, 1'b0);
    end else if (r < 72) begin
      // lone dot, followed by LF, blank or text
      send_word(ChLf, 1'b0);
      send_word(ChDot, 1'b0);
      r = $urandom_range(0, 2);
      send_word((r == 0) ? ChLf : (r == 1) ? ChSp : 8'($urandom_range(8'h21, 8'h7E)),
                1'b0);
    end else if (r < 80) begin
      // "From " at a line start, sometimes broken or ending in a tab
      if ($urandom_range(0, 3) != 0) send_word(ChLf, 1'b0);
      for (int i = 1; i <= 4; i++) begin
        if ($urandom_range(0, 9) == 0) send_word(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
        else                           send_word(FromSeq[i], 1'b0);
      end
      send_word(($urandom_range(0, 3) == 0) ? ChTab : ChSp, 1'b0);
    end else if (r < 94) begin
      send_word(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Stream start counts as a line start for "From ".
  task automatic test_from_at_start();
    for (int i = 1; i <= 5; i++) send_word(FromSeq[i], 1'b0);
    send_word(ChLf, 1'b0);
  endtask

  task automatic test_lone_dot_and_trailing_blank();
    send_word(ChDot, 1'b0);
    send_word(ChLf, 1'b0);
    send_word(ChTab, 1'b0);
    send_word(ChLf, 1'b0);
  endtask

  task automatic test_escapes();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(ChEq, 1'b0);
    send_word(ChDel, 1'b0);
    send_word(8'h1F, 1'b0);
    send_word(8'h7E, 1'b0);
  endtask

  // First mark flushes a soft break, second one lands on an empty line.
  task automatic test_end_of_input();
    send_word(8'($urandom_range(0, 255)), 1'b1);
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Limit dropped under the current column: next char breaks the line.
  task automatic test_lowered_limit();
    for (int i = 0; i < 4; i++) send_word(8'h61 + 8'(i), 1'b0);
    drain_encoder();
    set_line_length(10'd2);
    send_word(8'h65, 1'b0);
  endtask

  task automatic test_mixed_text(input logic [9:0] lim, input int unsigned n,
                                 input bit idle);
    int unsigned stop_at;
    drain_encoder();
    set_line_length(lim);
    tx_gaps   = idle;
    rx_stalls = idle;
    stop_at   = words_sent + n;
    while (words_sent < stop_at) send_text_chunk();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
  endtask

  // Widest limit: escapes only, no LF; 345 of them reach 1035 columns,
  // so the line crosses 1023 near the end.
  task automatic test_long_line();
    int r;
    drain_encoder();
    set_line_length(10'd1023);
    for (int i = 0; i < 345; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70)      send_word(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
      else if (r < 85) send_word(8'($urandom_range(8'h00, 8'h08)), 1'b0);
      else             send_word(ChEq, 1'b0);
    end
    send_word(8'h00, 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_from_at_start();
    test_lone_dot_and_trailing_blank();
    test_escapes();
    test_end_of_input();
    test_lowered_limit();

    test_mixed_text(10'd0, 30, 1'b1);
    test_mixed_text(10'd1, 20, 1'b1);
    test_mixed_text(10'd3, 20, 1'b1);
    test_mixed_text(10'd76, 30, 1'b0);
    test_mixed_text(10'($urandom_range(4, 200)), 30, 1'b1);
    test_long_line();

    drain_encoder();
    if (errors == 0 && encoded_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: quoted_printable_encoder_core.f
hw/rtl/qpe_pkg.sv
hw/rtl/qpe_front.sv
hw/rtl/qpe_fifo.sv
hw/rtl/qpe_back.sv
hw/rtl/quoted_printable_encoder_core.sv
test/tb.sv
